// ===== rtl/core/eyxz_pkg.sv =====
// Shared types, constants and fixed-point helpers for the Y-X-Z matrix generator.
package eyxz_pkg;

   localparam int CORDIC_STAGES  = 8;
   localparam int ITER_PER_STAGE = 3;
   localparam int DIV_STAGES     = 8;
   localparam int DIV_BITS       = 4;

   typedef logic signed [33:0] trig_type;
   typedef logic signed [32:0] phase_type;
   typedef logic signed [34:0] rot_type;

   localparam trig_type CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

   typedef struct packed {
      logic               action;
      logic        [15:0] angle_x;
      logic        [15:0] angle_y;
      logic        [15:0] angle_z;
      logic signed [15:0] scale_x;
      logic signed [15:0] scale_y;
      logic signed [15:0] scale_z;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } req_type;

   typedef struct packed {
      logic        [1:0]  column;
      logic signed [31:0] elem_x;
      logic signed [31:0] elem_y;
      logic signed [31:0] elem_z;
      logic signed [31:0] elem_w;
      logic               last;
   } rsp_type;

   // Arctangent of 2^-i, 2^32 counts per turn.
   function automatic phase_type atan_val(input int i);
      phase_type v;
      case (i)
         0:       v = 33'sh020000000;
         1:       v = 33'sh012E4051E;
         2:       v = 33'sh009FB385B;
         3:       v = 33'sh0051111D4;
         4:       v = 33'sh0028B0D43;
         5:       v = 33'sh00145D7E1;
         6:       v = 33'sh000A2F61E;
         7:       v = 33'sh000517C55;
         8:       v = 33'sh00028BE53;
         9:       v = 33'sh000145F2F;
         10:      v = 33'sh0000A2F98;
         11:      v = 33'sh0000517CC;
         12:      v = 33'sh000028BE6;
         13:      v = 33'sh0000145F3;
         14:      v = 33'sh000000A2FA;
         15:      v = 33'sh00000517D;
         16:      v = 33'sh0000028BE;
         17:      v = 33'sh00000145F;
         18:      v = 33'sh000000A30;
         19:      v = 33'sh000000518;
         20:      v = 33'sh00000028C;
         21:      v = 33'sh000000146;
         22:      v = 33'sh0000000A3;
         23:      v = 33'sh000000051;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Q2.30 product, rounded half up.
   function automatic trig_type qmul(input trig_type a, input trig_type b);
      logic signed [67:0] p;
      p = a * b;
      p = p + 68'sd536870912;
      return p[63:30];
   endfunction

endpackage

// ===== rtl/core/euler_yxz_model_normal_matrix.sv =====
// Top level of the Y-X-Z model and normal matrix generator.

// Each accepted word carries three binary angles, a Q8.8 scale per axis, a
// Q16.16 position and a mode bit, and produces four result words, one per
// matrix column in order 0 to 3, with last set on column 3. Model mode scales
// each rotation column by its scale and places the position in column 3 with
// w equal to 1.0; normal mode scales by the reciprocal of the scale and gives
// an all-zero column 3. The pipeline takes a word in any cycle it advances.
// The four-word output buffer paces the input: the pipeline, and so the
// input, moves on only when the buffer is empty or is handing over its
// last column. Stalls on either side lose and repeat nothing.
module euler_yxz_model_normal_matrix (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  eyxz_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output eyxz_pkg::rsp_type rsp_data
);

   // Stage 0 is the input register; sines, cosines and reciprocals are ready
   // at stage 9, the rotation at stage 11 and the scaled products at stage 12.
   localparam int DEPTH = 13;

   eyxz_pkg::req_type  pipe_ff  [DEPTH];
   logic               valid_ff [DEPTH];
   logic               adv;

   eyxz_pkg::trig_type sx, cx, sy, cy, sz, cz;
   logic signed [31:0] rcp      [3];
   logic signed [31:0] rcp10_ff [3];
   logic signed [31:0] rcp11_ff [3];
   eyxz_pkg::rot_type  rot      [9];
   logic signed [31:0] fac      [3];
   logic signed [66:0] prod_ff  [9];

   logic signed [31:0] elem_ff  [9];
   logic signed [31:0] elem_in  [9];
   logic signed [31:0] pos_ff   [3];
   logic               normal_ff;
   logic               buf_valid_ff, buf_valid_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic               fire;

   function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
      if (v > 67'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -67'sd2147483648) begin
         return 32'sh8000_0000;
      end else begin
         return v[31:0];
      end
   endfunction

   // The whole pipeline moves as one when the output buffer can take a word.
   assign fire      = buf_valid_ff && !rsp_stall;
   assign adv       = !buf_valid_ff || (fire && cnt_ff == 2'd3);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         valid_ff[0] <= req_valid;
         for (int k = 1; k < DEPTH; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pipe_ff[0] <= req_data;
         for (int k = 1; k < DEPTH; k++) begin
            pipe_ff[k] <= pipe_ff[k-1];
         end
      end
   end

   eyxz_sincos u_sincos_x (.clock(clock), .en(adv), .angle(pipe_ff[0].angle_x),
                           .sin_q(sx), .cos_q(cx));
   eyxz_sincos u_sincos_y (.clock(clock), .en(adv), .angle(pipe_ff[0].angle_y),
                           .sin_q(sy), .cos_q(cy));
   eyxz_sincos u_sincos_z (.clock(clock), .en(adv), .angle(pipe_ff[0].angle_z),
                           .sin_q(sz), .cos_q(cz));

   eyxz_recip u_recip_x (.clock(clock), .en(adv), .scale(pipe_ff[0].scale_x),
                         .recip(rcp[0]));
   eyxz_recip u_recip_y (.clock(clock), .en(adv), .scale(pipe_ff[0].scale_y),
                         .recip(rcp[1]));
   eyxz_recip u_recip_z (.clock(clock), .en(adv), .scale(pipe_ff[0].scale_z),
                         .recip(rcp[2]));

   eyxz_rot u_rot (
      .clock(clock), .en(adv),
      .sx(sx), .cx(cx), .sy(sy), .cy(cy), .sz(sz), .cz(cz),
      .rot(rot)
   );

   // Reciprocals wait two stages to meet the rotation.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            rcp10_ff[j] <= rcp[j];
            rcp11_ff[j] <= rcp10_ff[j];
         end
      end
   end

   always_comb begin
      if (pipe_ff[11].action) begin
         for (int j = 0; j < 3; j++) begin
            fac[j] = rcp11_ff[j];
         end
      end else begin
         fac[0] = 32'(pipe_ff[11].scale_x);
         fac[1] = 32'(pipe_ff[11].scale_y);
         fac[2] = 32'(pipe_ff[11].scale_z);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 9; k++) begin
            prod_ff[k] <= fac[k / 3] * rot[k];
         end
      end
   end

   // Rounding differs by mode: Q8.8 scale products drop 22 bits, Q16.16
   // reciprocal products drop 30.
   always_comb begin
      for (int k = 0; k < 9; k++) begin
         if (pipe_ff[12].action) begin
            elem_in[k] = sat32((prod_ff[k] + 67'sd536870912) >>> 30);
         end else begin
            elem_in[k] = sat32((prod_ff[k] + 67'sd2097152) >>> 22);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         elem_ff   <= elem_in;
         pos_ff[0] <= pipe_ff[12].pos_x;
         pos_ff[1] <= pipe_ff[12].pos_y;
         pos_ff[2] <= pipe_ff[12].pos_z;
         normal_ff <= pipe_ff[12].action;
      end
   end

   always_comb begin
      buf_valid_in = buf_valid_ff;
      cnt_in       = cnt_ff;
      if (adv) begin
         buf_valid_in = valid_ff[DEPTH-1];
         cnt_in       = 2'd0;
      end else if (fire) begin
         cnt_in = cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
         cnt_ff       <= 2'd0;
      end else begin
         buf_valid_ff <= buf_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   // The column counter selects which stored column goes out.
   always_comb begin
      rsp_data.column = cnt_ff;
      rsp_data.last   = (cnt_ff == 2'd3);
      case (cnt_ff)
         2'd0: begin
            rsp_data.elem_x = elem_ff[0];
            rsp_data.elem_y = elem_ff[1];
            rsp_data.elem_z = elem_ff[2];
            rsp_data.elem_w = '0;
         end
         2'd1: begin
            rsp_data.elem_x = elem_ff[3];
            rsp_data.elem_y = elem_ff[4];
            rsp_data.elem_z = elem_ff[5];
            rsp_data.elem_w = '0;
         end
         2'd2: begin
            rsp_data.elem_x = elem_ff[6];
            rsp_data.elem_y = elem_ff[7];
            rsp_data.elem_z = elem_ff[8];
            rsp_data.elem_w = '0;
         end
         default: begin
            if (normal_ff) begin
               rsp_data.elem_x = '0;
               rsp_data.elem_y = '0;
               rsp_data.elem_z = '0;
               rsp_data.elem_w = '0;
            end else begin
               rsp_data.elem_x = pos_ff[0];
               rsp_data.elem_y = pos_ff[1];
               rsp_data.elem_z = pos_ff[2];
               rsp_data.elem_w = eyxz_pkg::ONE_Q16;
            end
         end
      endcase
   end

   assign rsp_valid = buf_valid_ff;

   // Columns of one item follow each other without a gap in numbering.
   a_column_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_data.column != 2'd3)
      |=> (rsp_valid && rsp_data.column == $past(rsp_data.column) + 2'd1))
      else $error("column index did not advance by one");

   // Input is held back only while the buffer holds an unfinished item.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (buf_valid_ff && !(fire && cnt_ff == 2'd3)))
      else $error("input stalled without a busy output buffer");

   // A normal matrix has an all-zero fourth column.
   a_normal_col3: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.column == 2'd3 && normal_ff)
      |-> (rsp_data.elem_x == '0 && rsp_data.elem_y == '0 &&
           rsp_data.elem_z == '0 && rsp_data.elem_w == '0))
      else $error("normal matrix column 3 not zero");

endmodule

// ===== rtl/core/eyxz_sincos.sv =====
// Pipelined CORDIC giving sine and cosine of one binary angle in Q2.30.
module eyxz_sincos (
   input  logic               clock,
   input  logic               en,
   input  logic        [15:0] angle,
   output eyxz_pkg::trig_type sin_q,
   output eyxz_pkg::trig_type cos_q
);

   localparam int NS = eyxz_pkg::CORDIC_STAGES;
   localparam int NI = eyxz_pkg::ITER_PER_STAGE;

   eyxz_pkg::trig_type  x_ff [NS];
   eyxz_pkg::trig_type  y_ff [NS];
   eyxz_pkg::phase_type z_ff [NS];
   logic [1:0]          q_ff [NS];
   eyxz_pkg::trig_type  x_in [NS];
   eyxz_pkg::trig_type  y_in [NS];
   eyxz_pkg::phase_type z_in [NS];
   eyxz_pkg::trig_type  sin_ff, cos_ff, sin_in, cos_in;

   logic [15:0]         a_off;
   logic [1:0]          q0;
   logic [15:0]         r0;
   eyxz_pkg::phase_type z0;

   // Reduce to the nearest quadrant; residual lies within an eighth of a turn.
   assign a_off = angle + 16'h2000;
   assign q0    = a_off[15:14];
   assign r0    = angle - {q0, 14'b0};
   assign z0    = {r0[15], r0, 16'b0};

   for (genvar g = 0; g < NS; g++) begin : g_stage
      eyxz_pkg::trig_type  xs, ys;
      eyxz_pkg::phase_type zs;
      logic [1:0]          qs;
      if (g == 0) begin : g_first
         assign xs = eyxz_pkg::CORDIC_GAIN;
         assign ys = '0;
         assign zs = z0;
         assign qs = q0;
      end else begin : g_next
         assign xs = x_ff[g-1];
         assign ys = y_ff[g-1];
         assign zs = z_ff[g-1];
         assign qs = q_ff[g-1];
      end

      always_comb begin
         eyxz_pkg::trig_type  xv, yv, tv;
         eyxz_pkg::phase_type zv;
         xv = xs;
         yv = ys;
         zv = zs;
         for (int k = 0; k < NI; k++) begin
            if (!zv[32]) begin
               tv = xv - (yv >>> (g * NI + k));
               yv = yv + (xv >>> (g * NI + k));
               zv = zv - eyxz_pkg::atan_val(g * NI + k);
            end else begin
               tv = xv + (yv >>> (g * NI + k));
               yv = yv - (xv >>> (g * NI + k));
               zv = zv + eyxz_pkg::atan_val(g * NI + k);
            end
            xv = tv;
         end
         x_in[g] = xv;
         y_in[g] = yv;
         z_in[g] = zv;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[g] <= x_in[g];
            y_ff[g] <= y_in[g];
            z_ff[g] <= z_in[g];
            q_ff[g] <= qs;
         end
      end
   end

   // Rotate the result back into its quadrant.
   always_comb begin
      case (q_ff[NS-1])
         2'd0: begin
            sin_in = y_ff[NS-1];
            cos_in = x_ff[NS-1];
         end
         2'd1: begin
            sin_in = x_ff[NS-1];
            cos_in = -y_ff[NS-1];
         end
         2'd2: begin
            sin_in = -y_ff[NS-1];
            cos_in = -x_ff[NS-1];
         end
         default: begin
            sin_in = -x_ff[NS-1];
            cos_in = y_ff[NS-1];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_q = sin_ff;
   assign cos_q = cos_ff;

endmodule

// ===== rtl/core/eyxz_recip.sv =====
// Pipelined restoring divider giving the rounded Q16.16 reciprocal of a Q8.8 scale.
module eyxz_recip (
   input  logic               clock,
   input  logic               en,
   input  logic signed [15:0] scale,
   output logic signed [31:0] recip
);

   localparam int NS = eyxz_pkg::DIV_STAGES;
   localparam int NB = eyxz_pkg::DIV_BITS;

   logic [16:0] m_ff   [NS];
   logic [16:0] rem_ff [NS];
   logic [31:0] nq_ff  [NS];
   logic        neg_ff [NS];
   logic        zero_ff[NS];
   logic [16:0] rem_in [NS];
   logic [31:0] nq_in  [NS];

   logic [16:0] m0;
   logic [31:0] num0;
   logic signed [31:0] recip_ff, recip_in;

   assign m0   = scale[15] ? (17'd0 - {1'b1, scale}) : {1'b0, scale};
   assign num0 = 32'h0100_0000 + {16'b0, m0[16:1]};

   for (genvar g = 0; g < NS; g++) begin : g_stage
      logic [16:0] ms, rs;
      logic [31:0] ns;
      logic        negs, zeros;
      if (g == 0) begin : g_first
         assign ms    = m0;
         assign rs    = '0;
         assign ns    = num0;
         assign negs  = scale[15];
         assign zeros = (scale == 16'sd0);
      end else begin : g_next
         assign ms    = m_ff[g-1];
         assign rs    = rem_ff[g-1];
         assign ns    = nq_ff[g-1];
         assign negs  = neg_ff[g-1];
         assign zeros = zero_ff[g-1];
      end

      // Dividend bits shift out of the top while quotient bits shift in below.
      always_comb begin
         logic [16:0] rv;
         logic [31:0] nv;
         rv = rs;
         nv = ns;
         for (int k = 0; k < NB; k++) begin
            rv = {rv[15:0], nv[31]};
            nv = {nv[30:0], 1'b0};
            if (rv >= ms) begin
               rv    = rv - ms;
               nv[0] = 1'b1;
            end
         end
         rem_in[g] = rv;
         nq_in[g]  = nv;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            m_ff[g]    <= ms;
            rem_ff[g]  <= rem_in[g];
            nq_ff[g]   <= nq_in[g];
            neg_ff[g]  <= negs;
            zero_ff[g] <= zeros;
         end
      end
   end

   always_comb begin
      if (zero_ff[NS-1]) begin
         recip_in = 32'sh7FFF_FFFF;
      end else if (neg_ff[NS-1]) begin
         recip_in = -$signed(nq_ff[NS-1]);
      end else begin
         recip_in = $signed(nq_ff[NS-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         recip_ff <= recip_in;
      end
   end

   assign recip = recip_ff;

endmodule

// ===== rtl/core/eyxz_rot.sv =====
// Two-stage product network forming the Y-X-Z rotation matrix from sines and cosines.
module eyxz_rot (
   input  logic               clock,
   input  logic               en,
   input  eyxz_pkg::trig_type sx,
   input  eyxz_pkg::trig_type cx,
   input  eyxz_pkg::trig_type sy,
   input  eyxz_pkg::trig_type cy,
   input  eyxz_pkg::trig_type sz,
   input  eyxz_pkg::trig_type cz,
   output eyxz_pkg::rot_type  rot [9]
);

   eyxz_pkg::trig_type cycz_ff, sysx_ff, cysx_ff, czsy_ff, cysz_ff;
   eyxz_pkg::trig_type cxsz_ff, cxcz_ff, cxsy_ff, cycx_ff, sysz_ff;
   eyxz_pkg::trig_type sx_ff, sz_ff;
   eyxz_pkg::rot_type  rot_ff [9];
   eyxz_pkg::rot_type  rot_in [9];

   always_ff @(posedge clock) begin
      if (en) begin
         cycz_ff <= eyxz_pkg::qmul(cy, cz);
         sysx_ff <= eyxz_pkg::qmul(sy, sx);
         cysx_ff <= eyxz_pkg::qmul(cy, sx);
         czsy_ff <= eyxz_pkg::qmul(cz, sy);
         cysz_ff <= eyxz_pkg::qmul(cy, sz);
         cxsz_ff <= eyxz_pkg::qmul(cx, sz);
         cxcz_ff <= eyxz_pkg::qmul(cx, cz);
         cxsy_ff <= eyxz_pkg::qmul(cx, sy);
         cycx_ff <= eyxz_pkg::qmul(cy, cx);
         sysz_ff <= eyxz_pkg::qmul(sy, sz);
         sx_ff   <= sx;
         sz_ff   <= sz;
      end
   end

   // Entries are stored column-major: column times three plus row.
   always_comb begin
      rot_in[0] = eyxz_pkg::rot_type'(cycz_ff)
                + eyxz_pkg::rot_type'(eyxz_pkg::qmul(sysx_ff, sz_ff));
      rot_in[1] = eyxz_pkg::rot_type'(cxsz_ff);
      rot_in[2] = eyxz_pkg::rot_type'(eyxz_pkg::qmul(cysx_ff, sz_ff))
                - eyxz_pkg::rot_type'(czsy_ff);
      rot_in[3] = eyxz_pkg::rot_type'(eyxz_pkg::qmul(czsy_ff, sx_ff))
                - eyxz_pkg::rot_type'(cysz_ff);
      rot_in[4] = eyxz_pkg::rot_type'(cxcz_ff);
      rot_in[5] = eyxz_pkg::rot_type'(eyxz_pkg::qmul(cycz_ff, sx_ff))
                + eyxz_pkg::rot_type'(sysz_ff);
      rot_in[6] = eyxz_pkg::rot_type'(cxsy_ff);
      rot_in[7] = -eyxz_pkg::rot_type'(sx_ff);
      rot_in[8] = eyxz_pkg::rot_type'(cycx_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 9; k++) begin
            rot_ff[k] <= rot_in[k];
         end
      end
   end

   assign rot = rot_ff;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the Y-X-Z model and normal matrix generator.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int LATENCY_CYCLES = 40;
   localparam int ATAN_STEPS     = 24;
   localparam logic [63:0] GAIN_Q30 = 64'd652032874;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   eyxz_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   eyxz_pkg::rsp_type rsp_data;

   // Columns still owed by the block, oldest first.
   eyxz_pkg::rsp_type column_queue[$];
   int      error_count;
   int      idle_cycles;
   int      words_sent;
   int      columns_checked;
   int      send_idle_pct;
   int      recv_stall_pct;
   int      hold_off_cycles;

   euler_yxz_model_normal_matrix u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Arctangent of 2^-i at 2^32 counts per turn.
   function automatic longint arctan_step(input int i);
      longint tab[ATAN_STEPS];
      tab = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
              64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
              64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
              64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
              64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
      return tab[i];
   endfunction

   // Rounded floor shift; >>> on a signed longint is arithmetic.
   function automatic longint round_down_shift(input longint v, input int n);
      longint r;
      r = v + (longint'(1) <<< (n - 1));
      return r >>> n;
   endfunction

   function automatic longint q30_product(input longint a, input longint b);
      return round_down_shift(a * b, 30);
   endfunction

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // Sine and cosine in Q2.30 by quadrant folding and 24 CORDIC rotations.
   task automatic binary_angle_sincos(input logic [15:0] ang, output longint s,
                                      output longint c);
      logic [15:0] q16;
      logic [1:0]  quad;
      logic [15:0] resid;
      longint      x, y, z, t;
      q16   = ang + 16'h2000;
      quad  = q16[15:14];
      resid = ang - {quad, 14'd0};
      x = longint'(GAIN_Q30);
      y = 0;
      z = longint'($signed(resid)) * 65536;
      for (int i = 0; i < ATAN_STEPS; i++) begin
         if (z >= 0) begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            z = z - arctan_step(i);
         end else begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            z = z + arctan_step(i);
         end
         x = t;
      end
      case (quad)
         2'd0: begin s = y;  c = x;  end
         2'd1: begin s = x;  c = -y; end
         2'd2: begin s = -y; c = -x; end
         default: begin s = -x; c = y; end
      endcase
   endtask

   // Reciprocal of a Q8.8 scale as Q16.16, ties away from zero.
   function automatic longint scale_reciprocal(input logic signed [15:0] s);
      longint m, q;
      m = (s < 0) ? -longint'(s) : longint'(s);
      if (m == 0) return 64'sd2147483647;
      q = ((longint'(1) <<< 24) + m / 2) / m;
      return (s < 0) ? -q : q;
   endfunction

   // Works out the four columns of one word and queues them.
   task automatic predict_matrix_columns(input eyxz_pkg::req_type w);
      longint sx, cx, sy, cy, sz, cz;
      longint rot[3][3];
      longint fac[3];
      logic signed [15:0] scl[3];
      eyxz_pkg::rsp_type col;
      binary_angle_sincos(w.angle_x, sx, cx);
      binary_angle_sincos(w.angle_y, sy, cy);
      binary_angle_sincos(w.angle_z, sz, cz);
      rot[0][0] = q30_product(cy, cz) + q30_product(q30_product(sy, sx), sz);
      rot[0][1] = q30_product(cx, sz);
      rot[0][2] = q30_product(q30_product(cy, sx), sz) - q30_product(cz, sy);
      rot[1][0] = q30_product(q30_product(cz, sy), sx) - q30_product(cy, sz);
      rot[1][1] = q30_product(cx, cz);
      rot[1][2] = q30_product(q30_product(cy, cz), sx) + q30_product(sy, sz);
      rot[2][0] = q30_product(cx, sy);
      rot[2][1] = -sx;
      rot[2][2] = q30_product(cy, cx);
      scl = '{w.scale_x, w.scale_y, w.scale_z};
      for (int j = 0; j < 3; j++) begin
         fac[j] = w.action ? scale_reciprocal(scl[j]) : longint'(scl[j]);
         col.column = j[1:0];
         col.elem_x = clamp32(round_down_shift(fac[j] * rot[j][0], w.action ? 30 : 22));
         col.elem_y = clamp32(round_down_shift(fac[j] * rot[j][1], w.action ? 30 : 22));
         col.elem_z = clamp32(round_down_shift(fac[j] * rot[j][2], w.action ? 30 : 22));
         col.elem_w = '0;
         col.last   = 1'b0;
         column_queue.push_back(col);
      end
      col.column = 2'd3;
      col.last   = 1'b1;
      if (w.action) begin
         col.elem_x = '0;
         col.elem_y = '0;
         col.elem_z = '0;
         col.elem_w = '0;
      end else begin
         col.elem_x = w.pos_x;
         col.elem_y = w.pos_y;
         col.elem_z = w.pos_z;
         col.elem_w = eyxz_pkg::ONE_Q16;
      end
      column_queue.push_back(col);
   endtask

   // Offers one word, idling first at the current rate, and holds it until taken.
   // Valid stays high after acceptance so that back-to-back words need no gap.
   task automatic send_word(input eyxz_pkg::req_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      predict_matrix_columns(w);
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   function automatic eyxz_pkg::req_type random_word();
      eyxz_pkg::req_type w;
      w.action  = 1'($urandom_range(1));
      w.angle_x = 16'($urandom);
      w.angle_y = 16'($urandom);
      w.angle_z = 16'($urandom);
      w.scale_x = 16'($urandom);
      w.scale_y = 16'($urandom);
      w.scale_z = 16'($urandom);
      // Mostly modest scales so that saturation is not the common case.
      if ($urandom_range(3) != 0) begin
         w.scale_x = $signed(16'($urandom_range(2047))) - 16'sd1024;
         w.scale_y = $signed(16'($urandom_range(2047))) - 16'sd1024;
         w.scale_z = $signed(16'($urandom_range(2047))) - 16'sd1024;
      end
      w.pos_x = $urandom;
      w.pos_y = $urandom;
      w.pos_z = $urandom;
      return w;
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (column_queue.size() != 0) @(posedge clock);
   endtask

   // Directed words: angle and scale extremes, both modes, quadrant edges.
   task automatic test_directed();
      eyxz_pkg::req_type w;
      logic [15:0] angs[8];
      logic signed [15:0] scls[6];
      angs = '{16'h0000, 16'hFFFF, 16'h2000, 16'h1FFF, 16'h4000, 16'h8000,
               16'hC000, 16'hA000};
      scls = '{16'sh0000, 16'sh7FFF, -16'sh8000, 16'sh0100, -16'sh0001, 16'sh0001};
      for (int i = 0; i < 24; i++) begin
         w.action  = i[0];
         w.angle_x = angs[i % 8];
         w.angle_y = angs[(i + 3) % 8];
         w.angle_z = angs[(i + 5) % 8];
         w.scale_x = scls[i % 6];
         w.scale_y = scls[(i + 2) % 6];
         w.scale_z = scls[(i + 4) % 6];
         w.pos_x   = (i % 3 == 0) ? 32'sh7FFFFFFF : 32'sh80000000;
         w.pos_y   = (i % 3 == 1) ? 32'sh00000000 : 32'shFFFFFFFF;
         w.pos_z   = $urandom;
         send_word(w);
      end
      wait_drained();
   endtask

   // Random words under one pair of idle and stall rates.
   task automatic test_random_phase(input int n, input int idle_pct, input int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < n; i++) send_word(random_word());
      wait_drained();
   endtask

   // The receiver holds off while words keep coming, so the input backs up.
   task automatic test_backpressure();
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      hold_off_cycles = 150;
      for (int i = 0; i < 24; i++) send_word(random_word());
      // Pause the sender until every owed column is out.
      wait_drained();
   endtask

   // Receiver stall: a long hold-off when requested, otherwise random at the rate.
   initial begin
      rsp_stall = 1'b1;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_off_cycles--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // Checks each accepted column against the oldest one owed.
   always @(posedge clock) begin
      eyxz_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (column_queue.size() == 0) begin
            $error("column word with nothing expected: %p", rsp_data);
            error_count++;
         end else begin
            want = column_queue.pop_front();
            columns_checked++;
            if (rsp_data.column !== want.column) begin
               $error("column: expected %0d, got %0d", want.column, rsp_data.column);
               error_count++;
            end
            if (rsp_data.elem_x !== want.elem_x) begin
               $error("elem_x: expected %0d, got %0d", want.elem_x, rsp_data.elem_x);
               error_count++;
            end
            if (rsp_data.elem_y !== want.elem_y) begin
               $error("elem_y: expected %0d, got %0d", want.elem_y, rsp_data.elem_y);
               error_count++;
            end
            if (rsp_data.elem_z !== want.elem_z) begin
               $error("elem_z: expected %0d, got %0d", want.elem_z, rsp_data.elem_z);
               error_count++;
            end
            if (rsp_data.elem_w !== want.elem_w) begin
               $error("elem_w: expected %0d, got %0d", want.elem_w, rsp_data.elem_w);
               error_count++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_data.last);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no accepted word on either side.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
         $display("testbench: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data        = '0;
      error_count     = 0;
      idle_cycles     = 0;
      words_sent      = 0;
      columns_checked = 0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      hold_off_cycles = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_phase(35, 0, 0);
      test_random_phase(35, 51, 0);
      test_random_phase(35, 0, 51);
      test_random_phase(35, 20, 20);
      test_backpressure();
      repeat (LATENCY_CYCLES) @(posedge clock);
      $display("covered %0d words in model and normal mode, %0d columns checked,",
               words_sent, columns_checked);
      $display("with angle and scale extremes, idling, stalling and a long hold-off");
      if (error_count == 0 && column_queue.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
